FILE: src/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and character classes for the character stream
// tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Scanner mode while walking through a token.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } lex_mode_e;

  // Kind code carried with each result item.
  typedef enum logic [2:0] {
    KIND_KEYWORD  = 3'd0,
    KIND_IDENT    = 3'd1,
    KIND_OPERATOR = 3'd2,
    KIND_LITERAL  = 3'd3,
    KIND_END      = 3'd4,
    KIND_INVALID  = 3'd5
  } token_kind_e;

  // Keyword codes.
  localparam logic [1:0] KW_IF    = 2'd0;
  localparam logic [1:0] KW_ELSE  = 2'd1;
  localparam logic [1:0] KW_WHILE = 2'd2;
  localparam logic [1:0] KW_FOR   = 2'd3;
  localparam int unsigned KW_COUNT = 4;

  // Output field widths.
  localparam int unsigned OUT_START_W = 16;
  localparam int unsigned OUT_LEN_W   = 8;

  // Output queue depth and pointer width.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

  // One result item.
  typedef struct packed {
    token_kind_e            kind;
    logic [1:0]             kw_index;
    logic [OUT_START_W-1:0] start;
    logic [OUT_LEN_W-1:0]   length;
    logic                   trunc;
    logic [7:0]             op_char;
    logic                   last;
  } token_t;

  // Up to two result items produced by one character.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } token_pair_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h2f) ||
           (c == 8'h3d) || (c == 8'h3c) || (c == 8'h3e);
  endfunction

  // Length of each keyword.
  function automatic logic [2:0] kw_len(logic [1:0] k);
    logic [2:0] len;
    case (k)
      KW_IF:    len = 3'd2;
      KW_ELSE:  len = 3'd4;
      KW_WHILE: len = 3'd5;
      KW_FOR:   len = 3'd3;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  // Character i of keyword k; zero past its end.
  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] i);
    logic [39:0] text;
    logic [7:0]  c;
    case (k)
      KW_IF:    text = {8'h00, 8'h00, 8'h00, 8'h66, 8'h69};
      KW_ELSE:  text = {8'h00, 8'h65, 8'h73, 8'h6c, 8'h65};
      KW_WHILE: text = {8'h65, 8'h6c, 8'h69, 8'h68, 8'h77};
      KW_FOR:   text = {8'h00, 8'h00, 8'h72, 8'h6f, 8'h66};
      default:  text = '0;
    endcase
    case (i)
      3'd0:    c = text[7:0];
      3'd1:    c = text[15:8];
      3'd2:    c = text[23:16];
      3'd3:    c = text[31:24];
      3'd4:    c = text[39:32];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: src/cst_if.sv
// ----------------------------------------------------------------------------
// cst_char_if / cst_token_if
// Valid/ready channels for input characters and result items.
// ----------------------------------------------------------------------------
interface cst_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface cst_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [1:0]  keyword_index;
  logic [15:0] token_start;
  logic [7:0]  token_length;
  logic        truncated;
  logic [7:0]  operator_char;
  logic        last;

  modport source (
    output valid, output token_kind, output keyword_index, output token_start,
    output token_length, output truncated, output operator_char, output last,
    input ready
  );
  modport sink (
    input valid, input token_kind, input keyword_index, input token_start,
    input token_length, input truncated, input operator_char, input last,
    output ready
  );
endinterface

FILE: src/cst_lexer.sv
// ----------------------------------------------------------------------------
// cst_lexer
// Scanner state and the combinational character classification that turns one
// accepted character into zero, one or two result items.
// ----------------------------------------------------------------------------
module cst_lexer import cst_pkg::*; #(
  parameter int unsigned MAX_TOKEN     = 128,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  ch_i,
  output token_pair_t res_o
);

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN + 1);

  lex_mode_e                mode_q, mode_d;
  logic [LEN_W-1:0]         run_q, run_d;
  logic                     ovf_q, ovf_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [KW_COUNT-1:0]      match_q, match_d;

  logic   c_letter, c_digit, c_space, c_op, ident_ch;
  logic   extend, finish, idle_res;
  token_t fin_tok, idle_tok;
  logic   kw_hit;
  logic [1:0] kw_idx;
  logic [KW_COUNT-1:0] begin_match;
  logic [POSITION_BITS-1:0] pos_inc;

  assign c_letter = is_letter(ch_i);
  assign c_digit  = is_digit(ch_i);
  assign c_space  = is_space(ch_i);
  assign c_op     = is_op(ch_i);
  assign ident_ch = c_letter || c_digit || (ch_i == CH_UNDERSCORE);
  assign pos_inc  = pos_q + POSITION_BITS'(1);

  // A running token either absorbs this character or is closed by it.
  assign extend = ((mode_q == MODE_IDENT) && ident_ch) ||
                  ((mode_q == MODE_NUMBER) && c_digit);
  assign finish = ((mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER)) && !extend;

  // Keyword decision for the token being closed.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = KW_IF;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (match_q[k] && !ovf_q && (run_q == LEN_W'(kw_len(2'(k))))) begin
        kw_hit = 1'b1;
        kw_idx = 2'(k);
      end
    end
  end

  // Keywords whose first letter matches a new identifier.
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      begin_match[k] = (kw_char(2'(k), 3'd0) == ch_i);
    end
  end

  // Result item for the closed token.
  always_comb begin
    fin_tok          = '0;
    fin_tok.kind     = KIND_LITERAL;
    if (mode_q == MODE_IDENT) begin
      fin_tok.kind = kw_hit ? KIND_KEYWORD : KIND_IDENT;
      fin_tok.kw_index = kw_hit ? kw_idx : KW_IF;
    end
    fin_tok.start  = OUT_START_W'(start_q);
    fin_tok.length = OUT_LEN_W'(run_q);
    fin_tok.trunc  = ovf_q;
  end

  // Result item from handling the character in the idle state.
  always_comb begin
    idle_res       = 1'b0;
    idle_tok       = '0;
    idle_tok.kind  = KIND_INVALID;
    idle_tok.start = OUT_START_W'(pos_q);
    if (c_space || c_letter || c_digit) begin
      idle_res = 1'b0;
    end else if (ch_i == CH_NUL) begin
      idle_res      = 1'b1;
      idle_tok.kind = KIND_END;
    end else if (c_op) begin
      idle_res         = 1'b1;
      idle_tok.kind    = KIND_OPERATOR;
      idle_tok.length  = OUT_LEN_W'(1);
      idle_tok.op_char = ch_i;
    end else begin
      idle_res        = 1'b1;
      idle_tok.length = OUT_LEN_W'(1);
    end
  end

  // Pack the results in order and mark the final one. A character that
  // extends the running token is never handled in the idle state.
  always_comb begin
    res_o.count  = 2'(finish) + 2'(idle_res && !extend);
    res_o.first  = finish ? fin_tok : idle_tok;
    res_o.second = idle_tok;
    res_o.first.last  = (res_o.count == 2'd1);
    res_o.second.last = 1'b1;
  end

  // Next scanner state.
  always_comb begin
    mode_d  = mode_q;
    run_d   = run_q;
    ovf_d   = ovf_q;
    start_d = start_q;
    pos_d   = pos_q;
    match_d = match_q;
    if (extend) begin
      if (mode_q == MODE_IDENT) begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if ((run_q >= LEN_W'(kw_len(2'(k)))) ||
              (kw_char(2'(k), run_q[2:0]) != ch_i)) begin
            match_d[k] = 1'b0;
          end
        end
      end
      if (run_q >= LEN_W'(MAX_TOKEN)) begin
        ovf_d = 1'b1;
      end else begin
        run_d = run_q + LEN_W'(1);
      end
      pos_d = pos_inc;
    end else begin
      mode_d = MODE_IDLE;
      if (finish) begin
        run_d   = '0;
        ovf_d   = 1'b0;
        match_d = '1;
      end
      if (c_space || c_op) begin
        pos_d = pos_inc;
      end else if (c_letter || c_digit) begin
        mode_d  = c_letter ? MODE_IDENT : MODE_NUMBER;
        run_d   = LEN_W'(1);
        ovf_d   = 1'b0;
        start_d = pos_q;
        match_d = c_letter ? begin_match : '0;
        pos_d   = pos_inc;
      end else begin
        // End of input and invalid characters restart the position count.
        pos_d = '0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      run_q   <= '0;
      ovf_q   <= 1'b0;
      start_q <= '0;
      pos_q   <= '0;
      match_q <= '1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      run_q   <= run_d;
      ovf_q   <= ovf_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      match_q <= match_d;
    end
  end

  // Two results only come from a closed identifier or number.
  a_pair_closes_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (res_o.count == 2'd2)) |->
      ((res_o.first.kind == KIND_IDENT) || (res_o.first.kind == KIND_KEYWORD) ||
       (res_o.first.kind == KIND_LITERAL)))
    else $error("two results without a closed token");

  // A token in progress always has at least one character.
  a_active_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (run_q != '0))
    else $error("token in progress with zero length");

endmodule

FILE: src/cst_out_fifo.sv
// ----------------------------------------------------------------------------
// cst_out_fifo
// Four-entry result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
module cst_out_fifo import cst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  token_pair_t push_i,
  input  logic        pop_i,
  output logic        ready_o,
  output logic        valid_o,
  output token_t      head_o
);

  token_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_PTR_W:0]   count_q, count_d;
  logic                  do_pop;
  logic [FIFO_PTR_W-1:0] wr_next;

  // Room for a full pair is required before a character is taken.
  assign ready_o = (count_q <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = valid_o && pop_i;
  assign wr_next = wr_q + FIFO_PTR_W'(1);

  // Pointer and fill count updates.
  always_comb begin
    wr_d    = wr_q + FIFO_PTR_W'(push_i.count);
    rd_d    = do_pop ? rd_q + FIFO_PTR_W'(1) : rd_q;
    count_d = count_q + (FIFO_PTR_W + 1)'(push_i.count) - (FIFO_PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_pair_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> ready_o)
    else $error("results pushed without room");

endmodule

FILE: src/char_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// Character stream tokenizer: keywords, identifiers, numbers, operators.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one character per item; a NUL character marks end of input.
//   out_o carries result items: kind, keyword index, start position, length,
//   truncation flag, operator character and a last flag on the final result
//   that a character caused.
//   A character is scanned in the cycle it is accepted; its results enter a
//   four-entry output queue and reach out_o behind any earlier results, from the
//   next cycle on, one result per cycle while the receiver is ready.
//   One character can be taken every cycle while the queue has room for two
//   results; a character that closes a token and also gives a result of its
//   own produces two items, so a long run of those drains at one result per
//   cycle and input is taken at that pace.
//   When the receiver stalls, queued results hold and in_i.ready drops once
//   fewer than two queue entries are free.
//   Reset puts the scanner idle at position 0 and empties the queue.
// ----------------------------------------------------------------------------
module char_stream_tokenizer import cst_pkg::*; #(
  parameter int unsigned MAX_TOKEN     = 128,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cst_char_if.sink    in_i,
  cst_token_if.source out_o
);

  logic        accept;
  logic        fifo_ready;
  token_pair_t results;
  token_t      head;

  assign in_i.ready = fifo_ready;
  assign accept     = in_i.valid && fifo_ready;

  // Scanner.
  cst_lexer #(
    .MAX_TOKEN     (MAX_TOKEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (in_i.ch),
    .res_o    (results)
  );

  // Result queue; nothing is pushed unless a character is accepted.
  token_pair_t push;
  always_comb begin
    push       = results;
    push.count = accept ? results.count : 2'd0;
  end

  cst_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .ready_o (fifo_ready),
    .valid_o (out_o.valid),
    .head_o  (head)
  );

  // Output fields.
  assign out_o.token_kind    = head.kind;
  assign out_o.keyword_index = head.kw_index;
  assign out_o.token_start   = head.start;
  assign out_o.token_length  = head.length;
  assign out_o.truncated     = head.trunc;
  assign out_o.operator_char = head.op_char;
  assign out_o.last          = head.last;

endmodule
